// ===== src/mrfp_pkg.sv =====
// Shared types and constants for the Modbus response frame parser.
// No dependencies; used by every module under src.
`default_nettype none
package mrfp_pkg;

	// frame_mode codes
	localparam logic MODE_RTU = 1'b0;
	localparam logic MODE_TCP = 1'b1;

	// record_kind codes
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// frame_status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_CRC   = 2'd1;
	localparam logic [1:0] STAT_SHORT = 2'd2;

	// CRC-16 constants (reflected)
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_MASK = 16'h7FFF;

	// APB map: one register, index in paddr[2]
	localparam int          PADDR_W        = 3;
	localparam logic        REG_FRAME_MODE = 1'b0;

	// output queue
	localparam int OQ_DEPTH = 6;
	localparam int OQ_PTR_W = 3;
	localparam int OQ_CNT_W = 3;

	// stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;

	// one result record
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic [7:0] data_index;
		logic [7:0] device_address;
		logic [7:0] function_code;
		logic [7:0] byte_count;
		logic [1:0] frame_status;
		logic       run_last;
	} rec_t;

	// results pushed by the core in one cycle, r0 first
	typedef struct packed {
		logic v0;
		logic v1;
		rec_t r0;
		rec_t r1;
	} push_t;

	// one byte through the CRC-16 update, eight shift steps
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		logic        lsb;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			lsb = x[0];
			x   = (x >> 1) & CRC_MASK;
			if (lsb) begin
				x = x ^ CRC_POLY;
			end
		end
		return x;
	endfunction

endpackage
`default_nettype wire

// ===== src/mrfp_cfg.sv =====
// APB register file of the Modbus response frame parser: frame_mode.
// Depends on mrfp_pkg.
`default_nettype none
module mrfp_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mrfp_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output logic                             frame_mode
);

	logic frame_mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= mrfp_pkg::MODE_RTU;
		end else if (wr_en && paddr[2] == mrfp_pkg::REG_FRAME_MODE) begin
			frame_mode_q <= pwdata[0];
		end
	end

	// read decode
	always_comb begin
		unique case (paddr[2])
			mrfp_pkg::REG_FRAME_MODE: prdata = {31'd0, frame_mode_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign frame_mode = frame_mode_q;

endmodule
`default_nettype wire

// ===== src/mrfp_core.sv =====
// Frame parsing core: input register stage, CRC, field capture and
// result generation. Depends on mrfp_pkg.
`default_nettype none
module mrfp_core #(
	parameter int MAX_FRAME_BYTES = 260
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            frame_mode,
	input  wire logic            in_valid,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_eof,
	output mrfp_pkg::push_t      push
);

	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

	// input stage
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          eof_s1;

	// frame state
	logic [15:0]   crc_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    hold0_q, hold1_q;
	logic [7:0]    addr_q, func_q, count_q, emitted_q;

	// next state
	logic [15:0]   crc_n;
	logic [PW-1:0] pos_n;
	logic [7:0]    hold0_n, hold1_n;
	logic [7:0]    addr_n, func_n, count_n, emitted_n;

	logic          tv;
	logic [7:0]    tb;
	logic [PW-1:0] tq;
	logic          data_v;
	logic [PW-1:0] len;
	logic [1:0]    status;
	logic [15:0]   rx_crc;
	mrfp_pkg::rec_t data_rec, sum_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
			eof_s1  <= in_eof;
		end
	end

	// byte handling for the beat in stage 1
	always_comb begin
		crc_n     = crc_q;
		hold0_n   = hold0_q;
		hold1_n   = hold1_q;
		addr_n    = addr_q;
		func_n    = func_q;
		count_n   = count_q;
		emitted_n = emitted_q;
		data_v    = 1'b0;

		// pick the byte that reaches the parser: RTU delays by two
		if (frame_mode == mrfp_pkg::MODE_RTU) begin
			tv      = pos_q >= PW'(2);
			tb      = hold0_q;
			tq      = pos_q - PW'(2);
			hold0_n = hold1_q;
			hold1_n = byte_s1;
			if (tv) begin
				crc_n = mrfp_pkg::crc_byte(crc_q, hold0_q);
			end
		end else begin
			tv = pos_q >= PW'(6);
			tb = byte_s1;
			tq = pos_q - PW'(6);
		end

		if (tv) begin
			if (tq == PW'(0)) begin
				addr_n = tb;
			end else if (tq == PW'(1)) begin
				func_n = tb;
			end else if (tq == PW'(2)) begin
				count_n = tb;
			end else if (emitted_q < count_q) begin
				data_v    = 1'b1;
				emitted_n = emitted_q + 8'd1;
			end
		end

		// saturating length
		len = (pos_q == PW'(MAX_FRAME_BYTES)) ? pos_q : pos_q + PW'(1);
		pos_n = len;

		// end-of-frame status
		rx_crc = {hold1_n, hold0_n};
		if (frame_mode == mrfp_pkg::MODE_RTU) begin
			if (len < PW'(5)) begin
				status = mrfp_pkg::STAT_SHORT;
			end else if (rx_crc != crc_n) begin
				status = mrfp_pkg::STAT_CRC;
			end else begin
				status = mrfp_pkg::STAT_OK;
			end
		end else begin
			status = (len < PW'(9)) ? mrfp_pkg::STAT_SHORT : mrfp_pkg::STAT_OK;
		end

		data_rec.kind           = mrfp_pkg::KIND_DATA;
		data_rec.data_byte      = tb;
		data_rec.data_index     = emitted_q;
		data_rec.device_address = addr_n;
		data_rec.function_code  = func_n;
		data_rec.byte_count     = count_n;
		data_rec.frame_status   = mrfp_pkg::STAT_OK;
		data_rec.run_last       = ~eof_s1;

		sum_rec.kind           = mrfp_pkg::KIND_SUMMARY;
		sum_rec.data_byte      = 8'd0;
		sum_rec.data_index     = 8'd0;
		sum_rec.device_address = addr_n;
		sum_rec.function_code  = func_n;
		sum_rec.byte_count     = count_n;
		sum_rec.frame_status   = status;
		sum_rec.run_last       = 1'b1;

		// order: data record first, summary after
		push.v0 = valid_s1 & (data_v | eof_s1);
		push.v1 = valid_s1 & data_v & eof_s1;
		push.r0 = data_v ? data_rec : sum_rec;
		push.r1 = sum_rec;
	end

	// frame state update; summary returns it to the reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= mrfp_pkg::CRC_INIT;
			pos_q     <= '0;
			hold0_q   <= 8'd0;
			hold1_q   <= 8'd0;
			addr_q    <= 8'd0;
			func_q    <= 8'd0;
			count_q   <= 8'd0;
			emitted_q <= 8'd0;
		end else if (valid_s1) begin
			if (eof_s1) begin
				crc_q     <= mrfp_pkg::CRC_INIT;
				pos_q     <= '0;
				hold0_q   <= 8'd0;
				hold1_q   <= 8'd0;
				addr_q    <= 8'd0;
				func_q    <= 8'd0;
				count_q   <= 8'd0;
				emitted_q <= 8'd0;
			end else begin
				crc_q     <= crc_n;
				pos_q     <= pos_n;
				hold0_q   <= hold0_n;
				hold1_q   <= hold1_n;
				addr_q    <= addr_n;
				func_q    <= func_n;
				count_q   <= count_n;
				emitted_q <= emitted_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/mrfp_outq.sv =====
// Result queue: takes up to two records a cycle, hands out one a beat.
// Depends on mrfp_pkg.
`default_nettype none
module mrfp_outq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mrfp_pkg::push_t push,
	input  wire logic            pop,
	output logic                 out_valid,
	output mrfp_pkg::rec_t       out_rec,
	output logic [mrfp_pkg::OQ_CNT_W-1:0] count
);

	localparam int PTR_W = mrfp_pkg::OQ_PTR_W;

	mrfp_pkg::rec_t mem_q [mrfp_pkg::OQ_DEPTH];
	logic [PTR_W-1:0] head_q, tail_q, tail1;
	logic [mrfp_pkg::OQ_CNT_W-1:0] count_q;
	logic [1:0] n_push;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(mrfp_pkg::OQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign tail1     = ptr_inc(tail_q);
	assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
	assign out_valid = count_q != '0;
	assign out_rec   = mem_q[head_q];
	assign count     = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[tail1] <= push.r1;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop && out_valid) begin
				head_q <= ptr_inc(head_q);
			end
			if (push.v1) begin
				tail_q <= ptr_inc(tail1);
			end else if (push.v0) begin
				tail_q <= tail1;
			end
			count_q <= count_q + mrfp_pkg::OQ_CNT_W'(n_push)
				- mrfp_pkg::OQ_CNT_W'(pop && out_valid);
		end
	end

endmodule
`default_nettype wire

// ===== src/modbus_response_frame_parser.sv =====
// Modbus response frame parser, RTU (CRC-16) or TCP framing.
// Bytes in on the slave stream, data and summary records out on the master stream.
// Input beats: s_tdata = rx_byte, s_tlast = end_of_frame. frame_mode is set
// over APB at byte address 0 (0 RTU, 1 TCP); the user must write it only while
// idle, which the block itself does not enforce. Output beats: m_tuser =
// record_kind, m_tlast = run_last (last record of the input beat), m_tdata packs
// the remaining record fields. An accepted byte reaches the stage-1 register, is
// parsed in the next cycle and its records are then written into the result queue.
// Throughput: one byte per cycle while s_tready is high; both a data record and a
// summary for one byte take two output beats from the six-entry result queue.
// s_tready drops when the queue cannot absorb two more records for every
// byte in flight, so a stalled receiver backs up to the sender without loss.
// Reset clears frame state (CRC 0xFFFF, position and saved fields zero),
// empties the queue and selects RTU framing. After each summary the frame
// state returns to those values; the mode is kept.
// Depends on mrfp_pkg, mrfp_cfg, mrfp_core and mrfp_outq.
`default_nettype none
module modbus_response_frame_parser #(
	parameter int MAX_FRAME_BYTES = 260
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// APB configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mrfp_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready,
	// byte stream in
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [mrfp_pkg::IN_TDATA_W-1:0] s_tdata,  // [7:0] rx_byte
	input  wire logic                           s_tlast,   // end_of_frame
	// record stream out
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [7:0] data_byte, [15:8] data_index, [23:16] device_address,
	// [31:24] function_code, [39:32] byte_count, [41:40] frame_status, rest 0
	output logic [mrfp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tuser,   // record_kind
	output logic                                m_tlast    // run_last
);

	logic            frame_mode;
	logic            in_valid;
	logic            stage_busy;
	mrfp_pkg::push_t push;
	mrfp_pkg::rec_t  out_rec;
	logic [mrfp_pkg::OQ_CNT_W-1:0] q_count;
	logic [3:0]      committed;

	mrfp_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.frame_mode (frame_mode)
	);

	// room check: queued records plus two for the beat in stage 1 plus two new
	assign committed = {1'b0, q_count} + {1'b0, stage_busy, 2'b00} / 4'd2;
	assign s_tready  = committed <= 4'(mrfp_pkg::OQ_DEPTH - 2);
	assign in_valid  = s_tvalid & s_tready;

	// stage-1 occupancy mirror
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_busy <= 1'b0;
		end else begin
			stage_busy <= in_valid;
		end
	end

	mrfp_core #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_mode (frame_mode),
		.in_valid   (in_valid),
		.in_byte    (s_tdata),
		.in_eof     (s_tlast),
		.push       (push)
	);

	mrfp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.out_valid (m_tvalid),
		.out_rec   (out_rec),
		.count     (q_count)
	);

	// output beat packing
	assign m_tdata = {6'd0, out_rec.frame_status, out_rec.byte_count,
		out_rec.function_code, out_rec.device_address,
		out_rec.data_index, out_rec.data_byte};
	assign m_tuser = out_rec.kind;
	assign m_tlast = out_rec.run_last;

endmodule
`default_nettype wire
